// ----- hw/rtl/cbf_pkg.sv -----
package cbf_pkg;

    localparam int COORD_W = 32;
    localparam int EXT_W   = 31;
    localparam int CNT_W   = 7;

    localparam logic [EXT_W-1:0] ONE_Q16   = 31'd65536;
    localparam logic [CNT_W-1:0] SAT_COUNT = 7'd64;

    typedef logic signed [COORD_W-1:0] coord_t;

    // Points are stored as x0, y0, x1, y1, x2, y2, x3, y3.
    typedef struct packed {
        coord_t [7:0]     pts;
        logic [CNT_W-1:0] count;
    } seg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ----- hw/rtl/cubic_bezier_flattener_top.sv -----
// Cubic Bezier flattener.
// The input channel takes one segment per word (push/full): four control
// points in signed Q16.16. The result channel (empty/pop) returns the n
// points at t = i/n for i = 1..n, last_point set on the final one.
// The configuration channel (cfg_valid/cfg_ready) writes image_extent,
// which sets n from the control-polygon length; write it only when idle.
// The front end measures one segment with the bit-serial square root of
// each edge length and the serial count divide. The back end makes each
// point with the 8-step shared multiply-accumulate and the 32-step
// restoring divide that rounds the coordinates.
// A two-entry queue between the two ends lets the next segment be
// measured while the current one is sampled. When the receiver stalls,
// one finished point waits in the output register and the back end holds
// until it is taken.
// Reset clears the queue and the output and sets image_extent to 1.0.
module cubic_bezier_flattener_top
    import cbf_pkg::*;
#(
    parameter int MAX_SAMPLES = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  coord_t           start_x,
    input  coord_t           start_y,
    input  coord_t           ctrl_a_x,
    input  coord_t           ctrl_a_y,
    input  coord_t           ctrl_b_x,
    input  coord_t           ctrl_b_y,
    input  coord_t           end_x,
    input  coord_t           end_y,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [EXT_W-1:0] image_extent,
    output logic             empty,
    input  logic             pop,
    output coord_t           point_x,
    output coord_t           point_y,
    output logic             last_point
);

    q_status_t q_status;
    logic      q_wr;
    logic      q_rd;
    seg_t      q_wdata;
    seg_t      q_rdata;

    cbf_front #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .start_x(start_x),
        .start_y(start_y),
        .ctrl_a_x(ctrl_a_x),
        .ctrl_a_y(ctrl_a_y),
        .ctrl_b_x(ctrl_b_x),
        .ctrl_b_y(ctrl_b_y),
        .end_x(end_x),
        .end_y(end_y),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .image_extent(image_extent),
        .q_status(q_status),
        .q_wr(q_wr),
        .q_wdata(q_wdata)
    );

    cbf_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .wr(q_wr),
        .wdata(q_wdata),
        .rd(q_rd),
        .rdata(q_rdata),
        .status(q_status)
    );

    cbf_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .q_status(q_status),
        .q_rdata(q_rdata),
        .q_rd(q_rd),
        .empty(empty),
        .pop(pop),
        .point_x(point_x),
        .point_y(point_y),
        .last_point(last_point)
    );

endmodule

// ----- hw/rtl/cbf_queue.sv -----
module cbf_queue
    import cbf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr,
    input  seg_t      wdata,
    input  logic      rd,
    output seg_t      rdata,
    output q_status_t status
);

    seg_t       mem_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;
    logic       do_wr;
    logic       do_rd;

    assign do_wr = wr && (cnt_reg != 2'd2);
    assign do_rd = rd && (cnt_reg != 2'd0);
    assign rdata = mem_reg[rptr_reg];
    assign status.full  = (cnt_reg == 2'd2);
    assign status.empty = (cnt_reg == 2'd0);

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (do_rd)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

endmodule

// ----- hw/rtl/cbf_front.sv -----
module cbf_front
    import cbf_pkg::*;
#(
    parameter int MAX_SAMPLES = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  coord_t           start_x,
    input  coord_t           start_y,
    input  coord_t           ctrl_a_x,
    input  coord_t           ctrl_a_y,
    input  coord_t           ctrl_b_x,
    input  coord_t           ctrl_b_y,
    input  coord_t           end_x,
    input  coord_t           end_y,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [EXT_W-1:0] image_extent,
    input  q_status_t        q_status,
    output logic             q_wr,
    output seg_t             q_wdata
);

    localparam logic [3:0] F_IDLE = 4'd0;
    localparam logic [3:0] F_MAG  = 4'd1;
    localparam logic [3:0] F_SQA  = 4'd2;
    localparam logic [3:0] F_SQB  = 4'd3;
    localparam logic [3:0] F_SUM  = 4'd4;
    localparam logic [3:0] F_ROOT = 4'd5;
    localparam logic [3:0] F_ACC  = 4'd6;
    localparam logic [3:0] F_NUM  = 4'd7;
    localparam logic [3:0] F_SAT  = 4'd8;
    localparam logic [3:0] F_DIV  = 4'd9;
    localparam logic [3:0] F_PUSH = 4'd10;

    localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_SAMPLES);

    logic [3:0]       state_reg;
    logic [3:0]       state_next;
    logic [EXT_W-1:0] ext_reg;
    coord_t [7:0]     pts_reg;
    logic [1:0]       edge_reg;
    logic [5:0]       cnt_reg;
    logic [31:0]      magx_reg;
    logic [31:0]      magy_reg;
    logic [63:0]      sqa_reg;
    logic [63:0]      sqb_reg;
    logic [65:0]      rad_reg;
    logic [34:0]      rem_reg;
    logic [32:0]      root_reg;
    logic [34:0]      clen_reg;
    logic [43:0]      numer_reg;
    logic [EXT_W-1:0] r_reg;
    logic [30:0]      drem_reg;
    logic [CNT_W-1:0] q_reg;

    logic [2:0]       ix0;
    logic [2:0]       ix1;
    logic [32:0]      dx;
    logic [32:0]      dy;
    logic [32:0]      adx;
    logic [32:0]      ady;
    logic [36:0]      rem_sh;
    logic [36:0]      trial;
    logic [36:0]      rem_sub;
    logic [EXT_W-1:0] r_eff;
    logic [43:0]      numer_calc;
    logic [31:0]      dtrial;
    logic [CNT_W-1:0] n_low;
    logic [CNT_W-1:0] n_final;

    assign full      = (state_reg != F_IDLE);
    assign cfg_ready = 1'b1;

    assign ix0 = {edge_reg, 1'b0};
    assign ix1 = ix0 + 3'd2;
    assign dx  = {pts_reg[ix1][31], pts_reg[ix1]} - {pts_reg[ix0][31], pts_reg[ix0]};
    assign dy  = {pts_reg[ix1 | 3'd1][31], pts_reg[ix1 | 3'd1]}
               - {pts_reg[ix0 | 3'd1][31], pts_reg[ix0 | 3'd1]};
    assign adx = dx[32] ? (33'd0 - dx) : dx;
    assign ady = dy[32] ? (33'd0 - dy) : dy;

    assign rem_sh  = {rem_reg, rad_reg[65:64]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign rem_sub = rem_sh - trial;

    assign r_eff      = (ext_reg < ONE_Q16) ? ONE_Q16 : ext_reg;
    assign numer_calc = {2'b00, clen_reg, 7'd0} + {3'b000, clen_reg, 6'd0}
                      + {6'd0, clen_reg, 3'd0} + {13'd0, r_eff} - 44'd1;
    assign dtrial     = {drem_reg, numer_reg[5]};

    assign n_low   = (q_reg == '0) ? CNT_W'(1) : q_reg;
    assign n_final = (n_low > MAX_N) ? MAX_N : n_low;

    assign q_wr          = (state_reg == F_PUSH) && !q_status.full;
    assign q_wdata.pts   = pts_reg;
    assign q_wdata.count = n_final;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: if (push) state_next = F_MAG;
            F_MAG:  state_next = F_SQA;
            F_SQA:  state_next = F_SQB;
            F_SQB:  state_next = F_SUM;
            F_SUM:  state_next = F_ROOT;
            F_ROOT: if (cnt_reg == 6'd0) state_next = F_ACC;
            F_ACC:  state_next = (edge_reg == 2'd2) ? F_NUM : F_MAG;
            F_NUM:  state_next = F_SAT;
            F_SAT:  state_next = (numer_reg >= {7'd0, r_reg, 6'd0}) ? F_PUSH : F_DIV;
            F_DIV:  if (cnt_reg == 6'd0) state_next = F_PUSH;
            F_PUSH: if (!q_status.full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            ext_reg   <= ONE_Q16;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                ext_reg <= image_extent;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                pts_reg  <= {end_y, end_x, ctrl_b_y, ctrl_b_x,
                             ctrl_a_y, ctrl_a_x, start_y, start_x};
                edge_reg <= 2'd0;
                clen_reg <= '0;
            end
            F_MAG:
            begin
                magx_reg <= adx[31:0];
                magy_reg <= ady[31:0];
            end
            F_SQA: sqa_reg <= magx_reg * magx_reg;
            F_SQB: sqb_reg <= magy_reg * magy_reg;
            F_SUM:
            begin
                rad_reg  <= {2'b00, sqa_reg} + {2'b00, sqb_reg};
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= 6'd32;
            end
            F_ROOT:
            begin
                rad_reg <= {rad_reg[63:0], 2'b00};
                cnt_reg <= cnt_reg - 6'd1;
                if (rem_sh >= trial)
                begin
                    rem_reg  <= rem_sub[34:0];
                    root_reg <= {root_reg[31:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh[34:0];
                    root_reg <= {root_reg[31:0], 1'b0};
                end
            end
            F_ACC:
            begin
                clen_reg <= clen_reg + {2'b00, root_reg};
                edge_reg <= edge_reg + 2'd1;
            end
            F_NUM:
            begin
                numer_reg <= numer_calc;
                r_reg     <= r_eff;
            end
            F_SAT:
            begin
                q_reg    <= SAT_COUNT;
                drem_reg <= numer_reg[36:6];
                cnt_reg  <= 6'd5;
                if (numer_reg < {7'd0, r_reg, 6'd0})
                begin
                    q_reg <= '0;
                end
            end
            F_DIV:
            begin
                numer_reg <= {numer_reg[42:0], 1'b0};
                cnt_reg   <= cnt_reg - 6'd1;
                if (dtrial >= {1'b0, r_reg})
                begin
                    drem_reg <= 31'(dtrial - {1'b0, r_reg});
                    q_reg    <= {q_reg[CNT_W-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= dtrial[30:0];
                    q_reg    <= {q_reg[CNT_W-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

endmodule

// ----- hw/rtl/cbf_back.sv -----
module cbf_back
    import cbf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_status_t q_status,
    input  seg_t      q_rdata,
    output logic      q_rd,
    output logic      empty,
    input  logic      pop,
    output coord_t    point_x,
    output coord_t    point_y,
    output logic      last_point
);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_W1   = 3'd1;
    localparam logic [2:0] B_W2   = 3'd2;
    localparam logic [2:0] B_MAC  = 3'd3;
    localparam logic [2:0] B_PREP = 3'd4;
    localparam logic [2:0] B_DIV  = 3'd5;
    localparam logic [2:0] B_OUT  = 3'd6;

    localparam int WGT_W = 21;
    localparam int ACC_W = 52;

    logic [2:0]              state_reg;
    logic [2:0]              state_next;
    coord_t [7:0]            pts_reg;
    logic [CNT_W-1:0]        n_reg;
    logic [CNT_W-1:0]        i_reg;
    logic [13:0]             a2_reg;
    logic [13:0]             b2_reg;
    logic [13:0]             n2_reg;
    logic [18:0]             n3_reg;
    logic [WGT_W-1:0]        w_reg [4];
    logic [2:0]              k_reg;
    logic signed [ACC_W-1:0] accx_reg;
    logic signed [ACC_W-1:0] accy_reg;
    logic [19:0]             remx_reg;
    logic [19:0]             remy_reg;
    logic [31:0]             lowx_reg;
    logic [31:0]             lowy_reg;
    logic [31:0]             qx_reg;
    logic [31:0]             qy_reg;
    logic [19:0]             div_reg;
    logic [4:0]              cnt_reg;
    logic                    out_valid_reg;
    coord_t                  px_reg;
    coord_t                  py_reg;
    logic                    last_reg;

    logic [CNT_W-1:0]        a_val;
    logic signed [WGT_W+32:0] prod;
    logic signed [ACC_W-1:0] bias;
    logic [53:0]             dvx;
    logic [53:0]             dvy;
    logic [20:0]             tx;
    logic [20:0]             ty;
    logic                    room;
    logic                    load;

    assign a_val = n_reg - i_reg;
    assign prod  = $signed({1'b0, w_reg[k_reg[2:1]]}) * pts_reg[k_reg];
    assign bias  = $signed({2'b00, n3_reg, 31'd0});
    assign dvx   = {1'b0, 52'(unsigned'(accx_reg + bias)), 1'b0}
                 + {35'd0, n3_reg};
    assign dvy   = {1'b0, 52'(unsigned'(accy_reg + bias)), 1'b0}
                 + {35'd0, n3_reg};
    assign tx    = {remx_reg, lowx_reg[31]};
    assign ty    = {remy_reg, lowy_reg[31]};

    assign room  = !out_valid_reg || pop;
    assign load  = (state_reg == B_OUT) && room;
    assign q_rd  = (state_reg == B_IDLE) && !q_status.empty;

    assign empty      = !out_valid_reg;
    assign point_x    = px_reg;
    assign point_y    = py_reg;
    assign last_point = last_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: if (!q_status.empty) state_next = B_W1;
            B_W1:   state_next = B_W2;
            B_W2:   state_next = B_MAC;
            B_MAC:  if (k_reg == 3'd7) state_next = B_PREP;
            B_PREP: state_next = B_DIV;
            B_DIV:  if (cnt_reg == 5'd0) state_next = B_OUT;
            B_OUT:  if (room) state_next = (i_reg == n_reg) ? B_IDLE : B_W1;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            px_reg   <= {~qx_reg[31], qx_reg[30:0]};
            py_reg   <= {~qy_reg[31], qy_reg[30:0]};
            last_reg <= (i_reg == n_reg);
        end
        case (state_reg)
            B_IDLE:
            begin
                pts_reg <= q_rdata.pts;
                n_reg   <= q_rdata.count;
                i_reg   <= CNT_W'(1);
            end
            B_W1:
            begin
                a2_reg <= a_val * a_val;
                b2_reg <= i_reg * i_reg;
                n2_reg <= n_reg * n_reg;
            end
            B_W2:
            begin
                w_reg[0] <= WGT_W'(a2_reg) * WGT_W'(a_val);
                w_reg[1] <= WGT_W'(a2_reg) * WGT_W'(i_reg) * WGT_W'(3);
                w_reg[2] <= WGT_W'(b2_reg) * WGT_W'(a_val) * WGT_W'(3);
                w_reg[3] <= WGT_W'(b2_reg) * WGT_W'(i_reg);
                n3_reg   <= 19'(n2_reg) * 19'(n_reg);
                k_reg    <= 3'd0;
                accx_reg <= '0;
                accy_reg <= '0;
            end
            B_MAC:
            begin
                k_reg <= k_reg + 3'd1;
                if (k_reg[0])
                begin
                    accy_reg <= accy_reg + ACC_W'(prod);
                end
                else
                begin
                    accx_reg <= accx_reg + ACC_W'(prod);
                end
            end
            B_PREP:
            begin
                remx_reg <= dvx[51:32];
                remy_reg <= dvy[51:32];
                lowx_reg <= dvx[31:0];
                lowy_reg <= dvy[31:0];
                div_reg  <= {n3_reg, 1'b0};
                cnt_reg  <= 5'd31;
            end
            B_DIV:
            begin
                cnt_reg  <= cnt_reg - 5'd1;
                lowx_reg <= {lowx_reg[30:0], 1'b0};
                lowy_reg <= {lowy_reg[30:0], 1'b0};
                if (tx >= {1'b0, div_reg})
                begin
                    remx_reg <= 20'(tx - {1'b0, div_reg});
                    qx_reg   <= {qx_reg[30:0], 1'b1};
                end
                else
                begin
                    remx_reg <= tx[19:0];
                    qx_reg   <= {qx_reg[30:0], 1'b0};
                end
                if (ty >= {1'b0, div_reg})
                begin
                    remy_reg <= 20'(ty - {1'b0, div_reg});
                    qy_reg   <= {qy_reg[30:0], 1'b1};
                end
                else
                begin
                    remy_reg <= ty[19:0];
                    qy_reg   <= {qy_reg[30:0], 1'b0};
                end
            end
            B_OUT:
            begin
                if (room)
                begin
                    i_reg <= i_reg + CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != B_IDLE) |-> (i_reg != '0) && (i_reg <= n_reg))
        else $error("point index outside the segment's count");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_OUT) && !room |=> (state_reg == B_OUT))
        else $error("finished point dropped while the output was full");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        load && (i_reg == n_reg) |=> (state_reg == B_IDLE))
        else $error("sequencer kept running after the last point");

endmodule
